[rtl/array_set_table_assert.svh]
`ifndef ARRAY_SET_TABLE_ASSERT_SVH
`define ARRAY_SET_TABLE_ASSERT_SVH

// Check that prop holds at every rising clock edge outside reset.
`define AST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds at a rising clock edge outside reset.
`define AST_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/ast_pkg.sv]
package ast_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int ELEM_W = 32;
   localparam int MODE_W = 2;
   localparam int SIZE_W = 5;
   localparam int RSP_W  = 8;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

endpackage

[rtl/array_set_table.sv]
// Set of distinct 32-bit values held in an ordered table of CAPACITY entries.
// req channel: tuser carries the operation (insert, remove, query), tdata the
// element. One transaction is taken only while the sequencer is idle.
// rsp channel: one transaction per request with success, full_reject and the
// set size after the operation.
// Each request scans the table through one comparator, one stored entry per
// cycle from the table RAM's single read port; a hit ends the scan early.
// A remove then moves every later entry down one place, one per cycle.
// A request passes through the search state, for a remove that hits then the
// shift state, and then the response state, which loads the response. The
// sequencer returns to idle as the response is loaded and only then takes the
// next request, so a new request is not taken before the last one is through.
// A response waits in an output register while rsp_tready is low; the next
// request is accepted meanwhile, and its response holds in the sequencer
// until the output register frees.
// Reset empties the set at once; table contents past the size are never used.
`include "array_set_table_assert.svh"

module array_set_table #(
   parameter int CAPACITY = ast_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ast_pkg::ELEM_W-1:0]  req_tdata,   // [31:0] element
   input  logic [ast_pkg::MODE_W-1:0]  req_tuser,   // [1:0] mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ast_pkg::RSP_W-1:0]   rsp_tdata    // [0] success, [1] full_reject,
                                                    // [6:2] set_size, [7] zero
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_SHIFT, ST_RESP} state_type;

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                scan_ff, scan_in;
   logic                         pend_ff, pend_in;
   logic [AW-1:0]                pend_idx_ff, pend_idx_in;
   logic [ast_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [ast_pkg::ELEM_W-1:0]   elem_ff, elem_in;
   logic                         res_success_ff, res_success_in;
   logic                         res_reject_ff, res_reject_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic                         rsp_success_ff, rsp_success_in;
   logic                         rsp_reject_ff, rsp_reject_in;
   logic [ast_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [ast_pkg::ELEM_W-1:0]   wr_data;
   logic [AW-1:0]                rd_addr;
   logic [ast_pkg::ELEM_W-1:0]   rd_data;
   logic                         issue;
   logic                         match_now;
   logic [31:0]                  count_ext;

   ast_ram #(
      .WIDTH(ast_pkg::ELEM_W),
      .DEPTH(CAPACITY)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign issue     = (scan_ff < count_ff);
   assign match_now = pend_ff && (rd_data == elem_ff);
   assign count_ext = 32'(count_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      mode_in        = mode_ff;
      elem_in        = elem_ff;
      res_success_in = res_success_ff;
      res_reject_in  = res_reject_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_success_in = rsp_success_ff;
      rsp_reject_in  = rsp_reject_ff;
      rsp_size_in    = rsp_size_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = elem_ff;
      rd_addr        = scan_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               elem_in  = req_tdata;
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            pend_in     = issue && !match_now;
            pend_idx_in = scan_ff[AW-1:0];
            if (issue && !match_now) begin
               scan_in = scan_ff + CW'(1);
            end
            if (match_now || !issue) begin
               pend_in        = 1'b0;
               res_success_in = 1'b0;
               res_reject_in  = 1'b0;
               state_in       = ST_RESP;
               unique case (mode_ff)
                  ast_pkg::MODE_INSERT: begin
                     if (!match_now) begin
                        if (count_ff >= CAP_C) begin
                           res_reject_in = 1'b1;
                        end else begin
                           wr_en          = 1'b1;
                           count_in       = count_ff + CW'(1);
                           res_success_in = 1'b1;
                        end
                     end
                  end
                  ast_pkg::MODE_REMOVE: begin
                     if (match_now) begin
                        scan_in  = CW'(pend_idx_ff) + CW'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  ast_pkg::MODE_QUERY: begin
                     res_success_in = match_now;
                  end
                  default: begin
                     res_success_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - AW'(1);
               wr_data = rd_data;
            end
            pend_in     = issue;
            pend_idx_in = scan_ff[AW-1:0];
            if (issue) begin
               scan_in = scan_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               count_in       = count_ff - CW'(1);
               res_success_in = 1'b1;
               state_in       = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in  = 1'b1;
               rsp_success_in = res_success_ff;
               rsp_reject_in  = res_reject_ff;
               rsp_size_in    = count_ext[ast_pkg::SIZE_W-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      scan_ff        <= scan_in;
      pend_idx_ff    <= pend_idx_in;
      mode_ff        <= mode_in;
      elem_ff        <= elem_in;
      res_success_ff <= res_success_in;
      res_reject_ff  <= res_reject_in;
      rsp_success_ff <= rsp_success_in;
      rsp_reject_ff  <= rsp_reject_in;
      rsp_size_ff    <= rsp_size_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_size_ff, rsp_reject_ff, rsp_success_ff};

   `AST_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_C, "set size above capacity")

   `AST_ASSERT_NEVER(a_reject_success, clock, reset,
      rsp_tvalid_ff && rsp_reject_ff && rsp_success_ff, "reject and success together")

   `AST_ASSERT(a_rsp_from_resp, clock, reset,
      (!$past(reset) && $rose(rsp_tvalid_ff)) |-> ($past(state_ff) == ST_RESP),
      "response loaded outside response state")

   `AST_ASSERT(a_count_change, clock, reset,
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff) == ST_SEARCH || $past(state_ff) == ST_SHIFT),
      "set size changed outside search or shift")

endmodule

[rtl/ast_ram.sv]
module ast_ram #(
   parameter int WIDTH = ast_pkg::ELEM_W,
   parameter int DEPTH = ast_pkg::CAPACITY_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
